@@ rtl/core/timestamp_prefix_to_epoch_core_macros.svh @@
// Assertion macros used by the tpe_calc module of the timestamp prefix decoder
`ifndef TIMESTAMP_PREFIX_TO_EPOCH_CORE_MACROS_SVH
`define TIMESTAMP_PREFIX_TO_EPOCH_CORE_MACROS_SVH

// Same-cycle implication, checked on clk and dropped while rst_n is low
`define TPE_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and dropped while rst_n is low
`define TPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tpe_pkg.sv @@
// Shared constants and types of the timestamp prefix decoder
`timescale 1ns / 1ps

package tpe_pkg;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Field widths
  localparam int unsigned POS_W    = 5;
  localparam int unsigned DIG_W    = 7;
  localparam int unsigned EPOCH_W  = 39;
  localparam int unsigned PREFIX_W = 5;
  localparam int unsigned OFFSET_W = 17;

  // Prefix lengths and position saturation
  localparam logic [PREFIX_W-1:0] PFX_LOCAL = 5'd19;
  localparam logic [PREFIX_W-1:0] PFX_UTC   = 5'd20;
  localparam logic [POS_W-1:0]    POS_SAT   = 5'd21;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_LOCAL_OFFSET = 1'b0;  // register index, paddr[2]

  // Collected fields of the current line, handed from parser to pipeline
  typedef struct packed {
    logic [DIG_W-1:0] century;   // first two year digits
    logic [DIG_W-1:0] yoc;       // last two year digits
    logic [DIG_W-1:0] month;
    logic [DIG_W-1:0] day;
    logic [DIG_W-1:0] hour;
    logic [DIG_W-1:0] minute;
    logic [DIG_W-1:0] second;
    logic             sep_t;     // 'T' separator seen
    logic             fmt_ok;    // layout clean and long enough
  } tpe_line_t;

endpackage

@@ rtl/core/tpe_in_if.sv @@
// Byte stream channel into the decoder
`timescale 1ns / 1ps

interface tpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       line_end;

  modport source (output valid, output char_byte, output line_end, input ready);
  modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

@@ rtl/core/tpe_out_if.sv @@
// Result channel out of the decoder
`timescale 1ns / 1ps

interface tpe_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  stamp_valid;
  logic signed [tpe_pkg::EPOCH_W-1:0]    epoch_secs;
  logic [tpe_pkg::PREFIX_W-1:0]          prefix_length;
  logic                                  is_utc;

  modport source (output valid, output stamp_valid, output epoch_secs,
                  output prefix_length, output is_utc, input ready);
  modport sink   (input valid, input stamp_valid, input epoch_secs,
                  input prefix_length, input is_utc, output ready);
endinterface

@@ rtl/core/tpe_cfg_regs.sv @@
// APB-style register holding the local time zone offset
`timescale 1ns / 1ps

module tpe_cfg_regs (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tpe_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [tpe_pkg::CFG_DATA_W-1:0]         pwdata,
  output logic [tpe_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                   pready,
  output logic signed [tpe_pkg::OFFSET_W-1:0]    local_offset_o
);

  logic signed [tpe_pkg::OFFSET_W-1:0] offset_r;
  logic signed [tpe_pkg::OFFSET_W-1:0] offset_nxt;
  logic                                sel_offset;

  assign pready     = 1'b1;
  assign sel_offset = (paddr[2] == tpe_pkg::REG_LOCAL_OFFSET);

  // Take the write in the access phase
  always_comb begin
    offset_nxt = offset_r;
    if (psel && penable && pwrite && sel_offset) begin
      offset_nxt = $signed(pwdata[tpe_pkg::OFFSET_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else begin
      offset_r <= offset_nxt;
    end
  end

  // Read back sign-extended
  assign prdata         = sel_offset ? tpe_pkg::CFG_DATA_W'(offset_r) : '0;
  assign local_offset_o = offset_r;

endmodule

@@ rtl/core/tpe_parser.sv @@
// Per-byte layout check and digit collection for one log line
`timescale 1ns / 1ps

module tpe_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_take_i,
  input  logic                line_take_i,
  input  logic [7:0]          char_byte_i,
  output tpe_pkg::tpe_line_t  line_o
);

  logic [tpe_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [tpe_pkg::DIG_W-1:0] century_r, century_nxt;
  logic [tpe_pkg::DIG_W-1:0] yoc_r, yoc_nxt;
  logic [tpe_pkg::DIG_W-1:0] month_r, month_nxt;
  logic [tpe_pkg::DIG_W-1:0] day_r, day_nxt;
  logic [tpe_pkg::DIG_W-1:0] hour_r, hour_nxt;
  logic [tpe_pkg::DIG_W-1:0] minute_r, minute_nxt;
  logic [tpe_pkg::DIG_W-1:0] second_r, second_nxt;
  logic                      sep_t_r, sep_t_nxt;
  logic                      err_r, err_nxt;

  logic       is_digit;
  logic [3:0] digit;
  logic       is_blank;
  logic       long_enough;

  // Shift one decimal digit into a two-digit field
  function automatic logic [tpe_pkg::DIG_W-1:0] dec_push(
    input logic [tpe_pkg::DIG_W-1:0] acc,
    input logic [3:0]                d
  );
    logic [tpe_pkg::DIG_W-1:0] times_ten;
    times_ten = {acc[tpe_pkg::DIG_W-4:0], 3'b000} + {acc[tpe_pkg::DIG_W-2:0], 1'b0};
    return times_ten + tpe_pkg::DIG_W'(d);
  endfunction

  assign is_digit = (char_byte_i >= tpe_pkg::CH_ZERO) && (char_byte_i <= tpe_pkg::CH_NINE);
  assign digit    = 4'(char_byte_i - tpe_pkg::CH_ZERO);
  assign is_blank = (char_byte_i == tpe_pkg::CH_SPACE) ||
                    ((char_byte_i >= tpe_pkg::CH_TAB) && (char_byte_i <= tpe_pkg::CH_CR));

  // Check the byte at the current place and advance
  always_comb begin
    pos_nxt     = pos_r;
    century_nxt = century_r;
    yoc_nxt     = yoc_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    sep_t_nxt   = sep_t_r;
    err_nxt     = err_r;

    if (line_take_i) begin
      pos_nxt     = '0;
      century_nxt = '0;
      yoc_nxt     = '0;
      month_nxt   = '0;
      day_nxt     = '0;
      hour_nxt    = '0;
      minute_nxt  = '0;
      second_nxt  = '0;
      sep_t_nxt   = 1'b0;
      err_nxt     = 1'b0;
    end else if (byte_take_i) begin
      unique case (pos_r)
        5'd0, 5'd1: begin
          if (is_digit) century_nxt = dec_push(century_r, digit);
          else          err_nxt = 1'b1;
        end
        5'd2, 5'd3: begin
          if (is_digit) yoc_nxt = dec_push(yoc_r, digit);
          else          err_nxt = 1'b1;
        end
        5'd4, 5'd7: begin
          if (char_byte_i != tpe_pkg::CH_DASH) err_nxt = 1'b1;
        end
        5'd13, 5'd16: begin
          if (char_byte_i != tpe_pkg::CH_COLON) err_nxt = 1'b1;
        end
        5'd5, 5'd6: begin
          if (is_digit) month_nxt = dec_push(month_r, digit);
          else          err_nxt = 1'b1;
        end
        5'd8, 5'd9: begin
          if (is_digit) day_nxt = dec_push(day_r, digit);
          else          err_nxt = 1'b1;
        end
        5'd10: begin
          if (char_byte_i == tpe_pkg::CH_T)          sep_t_nxt = 1'b1;
          else if (char_byte_i != tpe_pkg::CH_SPACE) err_nxt = 1'b1;
        end
        5'd11, 5'd12: begin
          if (is_digit) hour_nxt = dec_push(hour_r, digit);
          else          err_nxt = 1'b1;
        end
        5'd14, 5'd15: begin
          if (is_digit) minute_nxt = dec_push(minute_r, digit);
          else          err_nxt = 1'b1;
        end
        5'd17, 5'd18: begin
          if (is_digit) second_nxt = dec_push(second_r, digit);
          else          err_nxt = 1'b1;
        end
        5'd19: begin
          // Z form wants 'Z' here, local form wants a blank or nothing
          if (sep_t_r) begin
            if (char_byte_i != tpe_pkg::CH_Z) err_nxt = 1'b1;
          end else if (!is_blank) begin
            err_nxt = 1'b1;
          end
        end
        5'd20: begin
          if (sep_t_r && !is_blank) err_nxt = 1'b1;
        end
        default: begin
        end
      endcase
      if (pos_r < tpe_pkg::POS_SAT) pos_nxt = pos_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      century_r <= '0;
      yoc_r     <= '0;
      month_r   <= '0;
      day_r     <= '0;
      hour_r    <= '0;
      minute_r  <= '0;
      second_r  <= '0;
      sep_t_r   <= 1'b0;
      err_r     <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      century_r <= century_nxt;
      yoc_r     <= yoc_nxt;
      month_r   <= month_nxt;
      day_r     <= day_nxt;
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
      second_r  <= second_nxt;
      sep_t_r   <= sep_t_nxt;
      err_r     <= err_nxt;
    end
  end

  // Present the line as it stands
  assign long_enough    = sep_t_r ? (pos_r >= tpe_pkg::PFX_UTC) : (pos_r >= tpe_pkg::PFX_LOCAL);
  assign line_o.century = century_r;
  assign line_o.yoc     = yoc_r;
  assign line_o.month   = month_r;
  assign line_o.day     = day_r;
  assign line_o.hour    = hour_r;
  assign line_o.minute  = minute_r;
  assign line_o.second  = second_r;
  assign line_o.sep_t   = sep_t_r;
  assign line_o.fmt_ok  = !err_r && long_enough;

endmodule

@@ rtl/core/tpe_calc.sv @@
// Date check and epoch arithmetic pipeline with result register
`timescale 1ns / 1ps
`include "timestamp_prefix_to_epoch_core_macros.svh"

module tpe_calc (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 line_take_i,
  input  tpe_pkg::tpe_line_t                   line_i,
  input  logic signed [tpe_pkg::OFFSET_W-1:0]  local_offset_i,
  output logic                                 free_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 out_stamp_o,
  output logic signed [tpe_pkg::EPOCH_W-1:0]   out_epoch_o,
  output logic [tpe_pkg::PREFIX_W-1:0]         out_prefix_o,
  output logic                                 out_utc_o
);

  localparam int unsigned CENT_W = 22;
  localparam int unsigned YOC_W  = 16;
  localparam int unsigned DOY_W  = 9;
  localparam int unsigned TOD_W  = 17;
  localparam int unsigned DAYS_W = 23;
  // Days from the shifted year origin to 1970-01-01, plus one for the 1-based day
  localparam logic [DAYS_W-1:0] DAY_BIAS = 23'd865566;
  localparam logic signed [tpe_pkg::EPOCH_W-1:0] DAY_SECS = 39'sd86400;

  // Length of a month, zero for a month number out of range
  function automatic logic [4:0] month_len(input logic [tpe_pkg::DIG_W-1:0] m,
                                           input logic leap);
    logic [4:0] len;
    unique case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                   len = 5'd30;
      7'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of the month in a year that starts in March
  function automatic logic [DOY_W-1:0] march_days(input logic [tpe_pkg::DIG_W-1:0] m);
    logic [DOY_W-1:0] d;
    unique case (m)
      7'd3:    d = 9'd0;
      7'd4:    d = 9'd31;
      7'd5:    d = 9'd61;
      7'd6:    d = 9'd92;
      7'd7:    d = 9'd122;
      7'd8:    d = 9'd153;
      7'd9:    d = 9'd184;
      7'd10:   d = 9'd214;
      7'd11:   d = 9'd245;
      7'd12:   d = 9'd275;
      7'd1:    d = 9'd306;
      7'd2:    d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Stage valids, reset
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, s4_v_nxt, out_v_nxt;

  // Stage payloads
  tpe_pkg::tpe_line_t s1_line_r;
  logic                                s2_ok_r, s2_sep_r;
  logic [CENT_W-1:0]                   s2_cent_r;
  logic [YOC_W-1:0]                    s2_yoc_r;
  logic [DOY_W-1:0]                    s2_doy_r;
  logic [TOD_W-1:0]                    s2_tod_r;
  logic                                s3_ok_r, s3_sep_r;
  logic signed [DAYS_W-1:0]            s3_days_r;
  logic [TOD_W-1:0]                    s3_tod_r;
  logic                                s4_ok_r, s4_sep_r;
  logic signed [tpe_pkg::EPOCH_W-1:0]  s4_secs_r;
  logic [TOD_W-1:0]                    s4_tod_r;
  logic                                out_stamp_r, out_utc_r;
  logic signed [tpe_pkg::EPOCH_W-1:0]  out_epoch_r;
  logic [tpe_pkg::PREFIX_W-1:0]        out_prefix_r;

  // Load enables: a stage takes data when empty or when it moves on
  logic free1, free2, free3, free4, free_out;

  assign free_out = !out_v_r || out_ready_i;
  assign free4    = !s4_v_r || free_out;
  assign free3    = !s3_v_r || free4;
  assign free2    = !s2_v_r || free3;
  assign free1    = !s1_v_r || free2;
  assign free_o   = free1;

  assign s1_v_nxt  = free1    ? line_take_i : s1_v_r;
  assign s2_v_nxt  = free2    ? s1_v_r      : s2_v_r;
  assign s3_v_nxt  = free3    ? s2_v_r      : s3_v_r;
  assign s4_v_nxt  = free4    ? s3_v_r      : s4_v_r;
  assign out_v_nxt = free_out ? s4_v_r      : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      s4_v_r  <= s4_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Stage 1: snapshot of the line at its end
  always_ff @(posedge clk) begin
    if (free1) s1_line_r <= line_i;
  end

  // Stage 2: range checks and the terms of the day count
  logic                         leap;
  logic [4:0]                   mdays;
  logic                         ok2_nxt;
  logic                         borrow;
  logic [tpe_pkg::DIG_W-1:0]    yy_adj, c_adj;
  logic [CENT_W-1:0]            cent_nxt;
  logic [YOC_W-1:0]             yoc_nxt;
  logic [DOY_W-1:0]             doy_nxt;
  logic [TOD_W-1:0]             tod_nxt;

  always_comb begin
    leap = (s1_line_r.yoc == 7'd0) ? (s1_line_r.century[1:0] == 2'd0)
                                   : (s1_line_r.yoc[1:0] == 2'd0);
    mdays   = month_len(s1_line_r.month, leap);
    ok2_nxt = s1_line_r.fmt_ok &&
              (s1_line_r.month >= 7'd1) && (s1_line_r.month <= 7'd12) &&
              (s1_line_r.day >= 7'd1) && (s1_line_r.day <= {2'b00, mdays}) &&
              (s1_line_r.hour <= 7'd23) && (s1_line_r.minute <= 7'd59) &&
              (s1_line_r.second <= 7'd59);
    // January and February count with the year before; every year is shifted by 400 years
    borrow = (s1_line_r.month <= 7'd2);
    if (!borrow) begin
      yy_adj = s1_line_r.yoc;
      c_adj  = s1_line_r.century + 7'd4;
    end else if (s1_line_r.yoc == 7'd0) begin
      yy_adj = 7'd99;
      c_adj  = s1_line_r.century + 7'd3;
    end else begin
      yy_adj = s1_line_r.yoc - 7'd1;
      c_adj  = s1_line_r.century + 7'd4;
    end
    cent_nxt = CENT_W'(c_adj) * 22'd36524 + CENT_W'(c_adj[6:2]);
    yoc_nxt  = YOC_W'(yy_adj) * 16'd365 + YOC_W'(yy_adj[6:2]);
    doy_nxt  = march_days(s1_line_r.month) + DOY_W'(s1_line_r.day);
    tod_nxt  = TOD_W'(s1_line_r.hour) * 17'd3600 + TOD_W'(s1_line_r.minute) * 17'd60
             + TOD_W'(s1_line_r.second);
  end

  always_ff @(posedge clk) begin
    if (free2) begin
      s2_ok_r   <= ok2_nxt;
      s2_sep_r  <= s1_line_r.sep_t;
      s2_cent_r <= cent_nxt;
      s2_yoc_r  <= yoc_nxt;
      s2_doy_r  <= doy_nxt;
      s2_tod_r  <= tod_nxt;
    end
  end

  // Stage 3: days since 1970-01-01
  logic signed [DAYS_W-1:0] days_nxt;

  assign days_nxt = $signed(DAYS_W'(s2_cent_r) + DAYS_W'(s2_yoc_r) + DAYS_W'(s2_doy_r)
                            - DAY_BIAS);

  always_ff @(posedge clk) begin
    if (free3) begin
      s3_ok_r   <= s2_ok_r;
      s3_sep_r  <= s2_sep_r;
      s3_days_r <= days_nxt;
      s3_tod_r  <= s2_tod_r;
    end
  end

  // Stage 4: days to seconds
  logic signed [tpe_pkg::EPOCH_W-1:0] secs_nxt;

  assign secs_nxt = tpe_pkg::EPOCH_W'(s3_days_r) * DAY_SECS;

  always_ff @(posedge clk) begin
    if (free4) begin
      s4_ok_r   <= s3_ok_r;
      s4_sep_r  <= s3_sep_r;
      s4_secs_r <= secs_nxt;
      s4_tod_r  <= s3_tod_r;
    end
  end

  // Result: add time of day, drop the zone offset for the local form
  logic signed [tpe_pkg::EPOCH_W-1:0] off_ext;
  logic [tpe_pkg::EPOCH_W-1:0]        epoch_sum;

  always_comb begin
    off_ext   = s4_sep_r ? '0 : tpe_pkg::EPOCH_W'(local_offset_i);
    epoch_sum = s4_secs_r + tpe_pkg::EPOCH_W'(s4_tod_r) - off_ext;
  end

  always_ff @(posedge clk) begin
    if (free_out) begin
      out_stamp_r  <= s4_ok_r;
      out_utc_r    <= s4_ok_r && s4_sep_r;
      out_epoch_r  <= s4_ok_r ? $signed(epoch_sum) : '0;
      out_prefix_r <= !s4_ok_r ? '0 : (s4_sep_r ? tpe_pkg::PFX_UTC : tpe_pkg::PFX_LOCAL);
    end
  end

  assign out_valid_o  = out_v_r;
  assign out_stamp_o  = out_stamp_r;
  assign out_epoch_o  = out_epoch_r;
  assign out_prefix_o = out_prefix_r;
  assign out_utc_o    = out_utc_r;

  // Checks
  `TPE_ASSERT_IMPLIES(a_stall_only_full, !free1,
    s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_v_r, "input stalled with a free stage")
  `TPE_ASSERT_NEXT(a_line_enters, line_take_i, s1_v_r, "line end lost at pipeline entry")
  `TPE_ASSERT_IMPLIES(a_reject_zero, out_v_r && !out_stamp_r,
    out_epoch_r == '0 && out_prefix_r == '0 && !out_utc_r, "rejected line with nonzero fields")
  `TPE_ASSERT_IMPLIES(a_prefix_form, out_v_r && out_stamp_r,
    (out_utc_r && out_prefix_r == tpe_pkg::PFX_UTC) ||
    (!out_utc_r && out_prefix_r == tpe_pkg::PFX_LOCAL), "prefix length disagrees with form")

endmodule

@@ rtl/core/timestamp_prefix_to_epoch_core.sv @@
// Top level of the log-line timestamp prefix decoder
`timescale 1ns / 1ps

// Usage
//   in_chan carries the bytes of a log line, one per transfer, then one transfer
//   with line_end set. The line is checked for a leading YYYY-MM-DD, 'T' or
//   space, HH:MM:SS, a 'Z' after the T form and a blank or the end after that.
//   Each line_end transfer yields exactly one transfer on out_chan; byte
//   transfers yield none. A rejected line gives all result fields zero.
//   After the line_end transfer the result passes through a five-register
//   pipeline (snapshot, date checks and day terms, day sum, day-to-second
//   multiply, result register) before it is presented.
//   Throughput: while in_chan ready is high, one transfer per cycle on in_chan,
//   bytes and line ends alike; the 39-bit epoch multiply is split off into
//   its own stage. When out_chan stalls the pipeline keeps filling; in_chan
//   ready drops only once all five registers hold pending lines.
//   The APB port writes local_offset_seconds at byte address 0; it is applied
//   to the space-separated (local time) form only; the user must write it
//   only while idle, not enforced by the block. Reset (rst_n low, synchronous)
//   empties the pipeline, clears the line state and sets the offset to zero.

module timestamp_prefix_to_epoch_core (
  input  logic                            clk,
  input  logic                            rst_n,
  tpe_in_if.sink                          in_chan,
  tpe_out_if.source                       out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpe_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tpe_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tpe_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic                                 free;
  logic                                 in_xfer;
  logic                                 byte_take;
  logic                                 line_take;
  logic signed [tpe_pkg::OFFSET_W-1:0]  local_offset;
  tpe_pkg::tpe_line_t                   line;

  // Sort input transfers into bytes and line ends
  assign in_chan.ready = free;
  assign in_xfer       = in_chan.valid && free;
  assign byte_take     = in_xfer && !in_chan.line_end;
  assign line_take     = in_xfer && in_chan.line_end;

  tpe_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .local_offset_o (local_offset)
  );

  tpe_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_take_i (byte_take),
    .line_take_i (line_take),
    .char_byte_i (in_chan.char_byte),
    .line_o      (line)
  );

  tpe_calc u_calc (
    .clk            (clk),
    .rst_n          (rst_n),
    .line_take_i    (line_take),
    .line_i         (line),
    .local_offset_i (local_offset),
    .free_o         (free),
    .out_valid_o    (out_chan.valid),
    .out_ready_i    (out_chan.ready),
    .out_stamp_o    (out_chan.stamp_valid),
    .out_epoch_o    (out_chan.epoch_secs),
    .out_prefix_o   (out_chan.prefix_length),
    .out_utc_o      (out_chan.is_utc)
  );

endmodule
